// ===== hw/rtl/srif_pkg.sv =====
// ----------------------------------------------------------------------------
// srif_pkg: shared constants and types of the spike-rejecting IIR filter
// Field widths, fixed-point constants and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package srif_pkg;

  // Default pressure width in bits
  localparam int PRESSURE_BITS_DEF = 17;

  // Fixed field widths
  localparam int TIME_W = 32;
  localparam int TAU_W  = 16;
  localparam int FRAC_W = 8;

  // Blend factor: Q16, at most 1.0, so 17 bits
  localparam int ALPHA_W   = 17;
  localparam int ALPHA_ONE = 65536;

  // Register reset value and rounding offset of the Q8 state
  localparam int TAU_RESET  = 500;
  localparam int ROUND_HALF = 128;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_PREP = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } srif_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srif_window.sv =====
// ----------------------------------------------------------------------------
// srif_window: three-sample window with median selection
// Holds the newest three samples and presents the candidate result:
// the newest sample until three are held, then the median stamped with
// the middle sample's time.
// ----------------------------------------------------------------------------
`default_nettype none

module srif_window
  import srif_pkg::*;
#(
  parameter int PRESSURE_BITS = PRESSURE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [PRESSURE_BITS-1:0] pa,
  input  logic [TIME_W-1:0]        ts,
  output logic [PRESSURE_BITS-1:0] cand_pa,
  output logic [TIME_W-1:0]        cand_ts
);

  logic [PRESSURE_BITS-1:0] wp_r [3];
  logic [TIME_W-1:0]        wt_r [3];
  logic [1:0]               fill_r;

  logic [PRESSURE_BITS-1:0] lo, hi, med;
  logic                     full;

  // Shift the window, oldest entry drops out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r[0] <= '0;
      wp_r[1] <= '0;
      wp_r[2] <= '0;
      wt_r[0] <= '0;
      wt_r[1] <= '0;
      wt_r[2] <= '0;
      fill_r  <= 2'd0;
    end else if (push) begin
      wp_r[0] <= wp_r[1];
      wp_r[1] <= wp_r[2];
      wp_r[2] <= pa;
      wt_r[0] <= wt_r[1];
      wt_r[1] <= wt_r[2];
      wt_r[2] <= ts;
      if (fill_r != 2'd3) begin
        fill_r <= fill_r + 2'd1;
      end
    end
  end

  // Median of three: clamp the newest between the other two
  always_comb begin
    lo = (wp_r[0] < wp_r[1]) ? wp_r[0] : wp_r[1];
    hi = (wp_r[0] < wp_r[1]) ? wp_r[1] : wp_r[0];
    if (wp_r[2] < lo) begin
      med = lo;
    end else if (wp_r[2] > hi) begin
      med = hi;
    end else begin
      med = wp_r[2];
    end
  end

  assign full    = (fill_r == 2'd3);
  assign cand_pa = full ? med : wp_r[2];
  assign cand_ts = full ? wt_r[1] : wt_r[2];

endmodule

`default_nettype wire

// ===== hw/rtl/srif_div.sv =====
// ----------------------------------------------------------------------------
// srif_div: bit-serial blend factor divider
// Computes (dt << 16) / (tau + dt) by restoring division, one quotient bit
// per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module srif_div
  import srif_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TIME_W-1:0]  dt,
  input  logic [TAU_W-1:0]   tau,
  output logic [ALPHA_W-1:0] alpha,
  output logic               done
);

  localparam int CntW = $clog2(ALPHA_W);
  localparam logic [CntW-1:0] LastCnt = CntW'(ALPHA_W - 1);

  logic [TIME_W:0]    rem_r, den_r;
  logic [ALPHA_W-1:0] low_r, quo_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r, done_r, den_nz_r;

  logic [TIME_W+1:0]  trial, diff;
  logic               ge;
  logic [TIME_W:0]    den_nxt;

  // Trial subtract of the divisor from the shifted remainder
  assign trial   = {rem_r, low_r[ALPHA_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = !diff[TIME_W+1];
  assign den_nxt = {1'b0, dt} + (TIME_W+1)'(tau);

  // Control: load on start, count one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder starts at dt/2, then low bits of the dividend shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= {2'b00, dt[TIME_W-1:1]};
      low_r    <= {dt[0], {(ALPHA_W-1){1'b0}}};
      den_r    <= den_nxt;
      den_nz_r <= |den_nxt;
      quo_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TIME_W:0] : trial[TIME_W:0];
      low_r <= {low_r[ALPHA_W-2:0], 1'b0};
      quo_r <= {quo_r[ALPHA_W-2:0], ge};
    end
  end

  assign alpha = den_nz_r ? quo_r : '0;
  assign done  = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/srif_mul.sv =====
// ----------------------------------------------------------------------------
// srif_mul: bit-serial filter step multiplier
// Forms (mag * alpha) >> 16 by shift-and-add, one alpha bit per cycle,
// most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module srif_mul
  import srif_pkg::*;
#(
  parameter int PRESSURE_BITS = PRESSURE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [PRESSURE_BITS+FRAC_W-1:0] mag,
  input  logic [ALPHA_W-1:0]              alpha,
  output logic [PRESSURE_BITS+FRAC_W-1:0] step,
  output logic                            done
);

  localparam int QW   = PRESSURE_BITS + FRAC_W;
  localparam int AccW = QW + ALPHA_W;
  localparam int CntW = $clog2(ALPHA_W);
  localparam logic [CntW-1:0] LastCnt = CntW'(ALPHA_W - 1);

  logic [AccW-1:0]    acc_r;
  logic [QW-1:0]      mag_r;
  logic [ALPHA_W-1:0] sh_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r, done_r;

  // Control: count one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: double the sum and add the multiplicand when the bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mag_r <= mag;
      sh_r  <= alpha;
    end else if (busy_r) begin
      acc_r <= {acc_r[AccW-2:0], 1'b0}
             + (sh_r[ALPHA_W-1] ? AccW'(mag_r) : '0);
      sh_r  <= {sh_r[ALPHA_W-2:0], 1'b0};
    end
  end

  // Drop the 16 fraction bits of alpha: truncates the magnitude toward zero
  assign step = acc_r[QW+ALPHA_W-2:ALPHA_W-1];
  assign done = done_r;

endmodule

`default_nettype wire

// ===== hw/rtl/spike_rejecting_iir_filter.sv =====
// ----------------------------------------------------------------------------
// spike_rejecting_iir_filter: median-of-three spike filter and Q8 IIR filter
// Each accepted sample enters a three-entry window; the newest sample (until
// three are held) or the median is sent on unless its time is not later than
// the last sent time, and each sent value updates a first-order Q8 filter.
// ----------------------------------------------------------------------------
// Throughput: one sample is worked on at a time, and in_tready stays low until
// it is done. A sample that primes the filter passes through select (S_EVAL),
// prepare (S_PREP) and output (S_OUT); a suppressed one is dropped after
// select; every other sample passes through select, prepare, the bit-serial
// divider for the blend factor (S_DIV), the bit-serial multiplier for the
// filter step (S_MUL), the state update (S_UPD) and the output state, which
// loads the output register once it is free and returns to idle. A finished
// result waits in the output register while the next sample is taken in; a
// second finished result waits until that register is free.
// time_constant_ms is written on the cfg channel and resets to 500.
`default_nettype none

module spike_rejecting_iir_filter
  import srif_pkg::*;
#(
  parameter int PRESSURE_BITS = PRESSURE_BITS_DEF,
  localparam int InW     = ((PRESSURE_BITS + TIME_W + 7) / 8) * 8,
  localparam int OutBits = 3 * PRESSURE_BITS + TIME_W + FRAC_W,
  localparam int OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: raw_pa, sample_time
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [InW-1:0]   in_tdata,
  // out_tdata: median_pa, median_time_ms, smooth_q8, smooth_pa
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OutW-1:0]  out_tdata,
  // time_constant_ms
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TAU_W-1:0] cfg_data
);

  localparam int QW = PRESSURE_BITS + FRAC_W;

  srif_state_t state_r;

  logic [TAU_W-1:0]         tau_r;
  logic                     sent_once_r, primed_r;
  logic [TIME_W-1:0]        last_sent_r, last_filt_r, dt_r;
  logic [PRESSURE_BITS-1:0] cand_pa_r;
  logic [TIME_W-1:0]        cand_ts_r;
  logic [QW-1:0]            fv_r, mag_r;
  logic                     neg_r;

  logic                     out_valid_r;
  logic [PRESSURE_BITS-1:0] o_med_r, o_fpa_r;
  logic [TIME_W-1:0]        o_time_r;
  logic [QW-1:0]            o_q8_r;

  logic                     in_xfer;
  logic [PRESSURE_BITS-1:0] in_pa, win_pa;
  logic [TIME_W-1:0]        in_ts, win_ts, d_sent;
  logic                     send;
  logic [QW-1:0]            target;
  logic [QW:0]              rounded;
  logic                     slot_free;

  logic                     div_start, div_done, mul_start, mul_done;
  logic [ALPHA_W-1:0]       div_alpha;
  logic [QW-1:0]            mul_step;

  assign in_pa     = in_tdata[PRESSURE_BITS-1:0];
  assign in_ts     = in_tdata[PRESSURE_BITS+TIME_W-1:PRESSURE_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Window and candidate selection
  srif_window #(.PRESSURE_BITS(PRESSURE_BITS)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_xfer),
    .pa      (in_pa),
    .ts      (in_ts),
    .cand_pa (win_pa),
    .cand_ts (win_ts)
  );

  // Send only if strictly later than the last sent time (wrapping compare)
  assign d_sent = win_ts - last_sent_r;
  assign send   = !sent_once_r || ((d_sent != '0) && !d_sent[TIME_W-1]);

  // Magnitude and direction of the step toward the new value
  assign target = {cand_pa_r, {FRAC_W{1'b0}}};

  assign div_start = (state_r == S_PREP) && primed_r;
  assign mul_start = (state_r == S_DIV) && div_done;

  srif_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dt    (dt_r),
    .tau   (tau_r),
    .alpha (div_alpha),
    .done  (div_done)
  );

  srif_mul #(.PRESSURE_BITS(PRESSURE_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag   (mag_r),
    .alpha (div_alpha),
    .step  (mul_step),
    .done  (mul_done)
  );

  // Round the Q8 state to whole pascals
  assign rounded   = {1'b0, fv_r} + (QW+1)'(ROUND_HALF);
  assign slot_free = !out_valid_r || out_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r <= TAU_W'(TAU_RESET);
    end else if (cfg_valid && cfg_ready) begin
      tau_r <= cfg_data;
    end
  end

  // Sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sent_once_r <= 1'b0;
      primed_r    <= 1'b0;
      last_sent_r <= '0;
      last_filt_r <= '0;
      fv_r        <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (send) begin
            sent_once_r <= 1'b1;
            last_sent_r <= win_ts;
            last_filt_r <= win_ts;
            state_r     <= S_PREP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PREP: begin
          if (!primed_r) begin
            fv_r     <= target;
            primed_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          fv_r    <= neg_r ? fv_r - mul_step : fv_r + mul_step;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold the candidate and the step operands
  always_ff @(posedge clk) begin
    if (state_r == S_EVAL) begin
      cand_pa_r <= win_pa;
      cand_ts_r <= win_ts;
      dt_r      <= win_ts - last_filt_r;
    end
    if (state_r == S_PREP) begin
      neg_r <= (fv_r > target);
      mag_r <= (fv_r > target) ? fv_r - target : target - fv_r;
    end
  end

  // Output register: load when the slot is free, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      o_med_r  <= cand_pa_r;
      o_time_r <= cand_ts_r;
      o_q8_r   <= fv_r;
      o_fpa_r  <= rounded[QW-1:FRAC_W];
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                = '0;
    out_tdata[OutBits-1:0]   = {o_fpa_r, o_q8_r, o_time_r, o_med_r};
  end

  // Checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its state");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside its state");

  a_alpha_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> div_alpha <= ALPHA_W'(ALPHA_ONE))
    else $error("blend factor above one");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> mul_step <= mag_r)
    else $error("filter step overshoots target");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule

`default_nettype wire

// ===== tb/spike_rejecting_iir_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spike_rejecting_iir_filter_tb: self-checking bench of the pressure filter
// Drives timestamped samples over the input stream and recomputes the median,
// the time-order suppression and the Q8 IIR step for every transfer. Each
// result transfer is compared field by field with the oldest expected one.
// The bench covers directed edge cases, random phases over several time
// constants, random sender gaps, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------

module spike_rejecting_iir_filter_tb;
  import srif_pkg::*;

  localparam int PA_W        = PRESSURE_BITS_DEF;
  localparam int Q8_W        = PA_W + FRAC_W;
  localparam int IN_W        = ((PA_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_W       = ((3 * PA_W + TIME_W + FRAC_W + 7) / 8) * 8;
  localparam int PA_MAX      = (1 << PA_W) - 1;
  localparam int SETTLE_CYC  = 60;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 4000;

  // Receiver behavior
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  typedef struct packed {
    logic [PA_W-1:0]   median_pa;
    logic [TIME_W-1:0] median_time_ms;
    logic [Q8_W-1:0]   smooth_q8;
    logic [PA_W-1:0]   smooth_pa;
  } pressure_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TAU_W-1:0] cfg_data = '0;

  // Shadow state of the filter
  logic [PA_W-1:0]   win_pa [3];
  logic [TIME_W-1:0] win_ts [3];
  int unsigned       win_count = 0;
  bit                any_sent = 1'b0;
  logic [TIME_W-1:0] last_sent_ts = '0;
  logic [Q8_W-1:0]   iir_q8 = '0;
  bit                iir_primed = 1'b0;
  logic [TIME_W-1:0] last_iir_ts = '0;
  logic [TAU_W-1:0]  tau_ms = TAU_W'(TAU_RESET);

  pressure_result_t pending_results [$];
  int unsigned      mismatch_count = 0;
  int unsigned      idle_cycles = 0;

  // Stimulus shaping
  int unsigned rx_mode = RX_RANDOM;
  logic [7:0]  rx_pattern = 8'b1011_0111;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;

  spike_rejecting_iir_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shift one sample into the window and work out the result it causes, if any
  function automatic bit track_sample(input logic [PA_W-1:0] pa,
                                      input logic [TIME_W-1:0] ts,
                                      output pressure_result_t res);
    logic [PA_W-1:0]   cand_pa, lo, hi;
    logic [TIME_W-1:0] cand_ts, ahead, step_ms;
    longint unsigned   num, den, alpha;
    longint            diff, delta;
    logic [Q8_W:0]     rounded;
    win_pa[0] = win_pa[1];
    win_ts[0] = win_ts[1];
    win_pa[1] = win_pa[2];
    win_ts[1] = win_ts[2];
    win_pa[2] = pa;
    win_ts[2] = ts;
    if (win_count < 3) win_count++;
    cand_pa = pa;
    cand_ts = ts;
    res = '0;
    if (win_count == 3) begin
      lo = (win_pa[0] < win_pa[1]) ? win_pa[0] : win_pa[1];
      hi = (win_pa[0] < win_pa[1]) ? win_pa[1] : win_pa[0];
      cand_pa = (win_pa[2] < lo) ? lo : ((win_pa[2] > hi) ? hi : win_pa[2]);
      cand_ts = win_ts[1];
    end
    // Drop a candidate that is not strictly later than the last one sent
    ahead = cand_ts - last_sent_ts;
    if (any_sent && (ahead == '0 || ahead[TIME_W-1])) return 1'b0;
    any_sent = 1'b1;
    last_sent_ts = cand_ts;
    step_ms = cand_ts - last_iir_ts;
    last_iir_ts = cand_ts;
    if (!iir_primed) begin
      iir_q8 = {cand_pa, {FRAC_W{1'b0}}};
      iir_primed = 1'b1;
    end else begin
      num = 64'(step_ms) << 16;
      den = 64'(tau_ms) + 64'(step_ms);
      alpha = (den == 0) ? 0 : num / den;
      diff = longint'({cand_pa, {FRAC_W{1'b0}}}) - longint'(iir_q8);
      delta = diff * longint'(alpha);
      iir_q8 = Q8_W'(longint'(iir_q8) + delta / ALPHA_ONE);
    end
    rounded = {1'b0, iir_q8} + (Q8_W + 1)'(ROUND_HALF);
    res.median_pa = cand_pa;
    res.median_time_ms = cand_ts;
    res.smooth_q8 = iir_q8;
    res.smooth_pa = rounded[Q8_W-1:FRAC_W];
    return 1'b1;
  endfunction

  // Offer one sample, honoring the burst/gap pattern, and wait for its transfer
  task automatic send_sample(input logic [PA_W-1:0] pa, input logic [TIME_W-1:0] ts);
    pressure_result_t res;
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W - PA_W - TIME_W){1'b0}}, ts, pa};
    do @(posedge clk); while (!in_tready);
    if (track_sample(pa, ts, res)) pending_results.push_back(res);
  endtask

  // Drop valid, wait for every expected result, then let in-flight work finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write the time constant while the block is idle
  task automatic set_time_constant(input logic [TAU_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tau_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Window filling from reset, median selection and pressure extremes
  task automatic test_window_fill();
    send_sample(17'd1000, 32'd0);
    send_sample(17'd2000, 32'd100);
    send_sample(17'd1500, 32'd200);
    send_sample(17'(PA_MAX), 32'd300);
    send_sample(17'd1600, 32'd400);
    send_sample(17'd0, 32'd500);
    send_sample(17'd1700, 32'd600);
  endtask

  // Equal, earlier and wrapping timestamps, and the half-range boundary
  task automatic test_time_order();
    settle();
    send_sample(17'd1800, 32'd600);
    send_sample(17'd1800, 32'd550);
    send_sample(17'd1900, 32'hFFFF_FF00);
    send_sample(17'd1900, 32'hFFFF_FFFF);
    send_sample(17'd2000, 32'h0000_0010);
    send_sample(17'd2000, 32'h8000_0010);
    send_sample(17'd2100, 32'h8000_0011);
    send_sample(17'd2200, 32'h8000_0020);
  endtask

  // Zero time constant (jump), the largest one, and the smallest nonzero one
  task automatic test_time_constant();
    set_time_constant('0);
    send_sample(17'd5000, 32'h8000_0100);
    send_sample(17'd9000, 32'h8000_0200);
    send_sample(17'd7000, 32'h8000_0300);
    set_time_constant('1);
    send_sample(17'd100, 32'h8000_0400);
    send_sample(17'd120000, 32'h8000_0500);
    send_sample(17'd90000, 32'h8000_0600);
    set_time_constant(16'd1);
    send_sample(17'd40000, 32'h8000_0700);
    send_sample(17'd41000, 32'h8000_0800);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    logic [TIME_W-1:0] cursor;
    int unsigned k;
    settle();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    cursor = $urandom;
    hold_request = HOLD_CYC;
    for (k = 0; k < 12; k++) begin
      cursor = cursor + $urandom_range(1, 100);
      send_sample(17'($urandom), cursor);
    end
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
  endtask

  // Mostly well-formed drifting sample streams, with spikes and timing noise
  task automatic test_random_phase(input int unsigned n_items, input logic [TAU_W-1:0] tau,
                                   input int unsigned mode, input bit gaps);
    int unsigned       pick, k;
    int                level, spread;
    logic [TIME_W-1:0] cursor, ts;
    logic [PA_W-1:0]   pa;
    set_time_constant(tau);
    rx_mode = mode;
    rx_pattern = 8'($urandom) | 8'h01;
    gaps_on = gaps;
    cursor = $urandom;
    level = $urandom_range(0, PA_MAX);
    spread = $urandom_range(0, 400);
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        if (pick < 2) level = $urandom_range(0, PA_MAX);
        cursor = cursor + ((pick < 4) ? $urandom_range(1000, 32'h7FFF_FFFF)
                                      : $urandom_range(1, 250));
        level = level + $urandom_range(0, 2 * spread) - spread;
        if (level < 0) level = 0;
        if (level > PA_MAX) level = PA_MAX;
        pa = 17'(level);
        ts = cursor;
      end else if (pick < 88) begin
        // spike
        cursor = cursor + $urandom_range(1, 250);
        ts = cursor;
        if ($urandom_range(0, 3) == 0) pa = 17'($urandom);
        else pa = $urandom_range(0, 1) ? 17'(PA_MAX) : '0;
      end else if (pick < 95) begin
        // repeated or stale timestamp
        ts = cursor - $urandom_range(0, 40);
        pa = 17'(level);
      end else begin
        cursor = $urandom;
        ts = cursor;
        pa = 17'($urandom);
      end
      send_sample(pa, ts);
    end
  endtask

  // Receiver readiness: hold-off, then the current stall pattern
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          out_tready <= 1'b1;
        end
        RX_PATTERN: begin
          rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
          out_tready <= rx_pattern[0];
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  function automatic void compare_field(input string name, input logic [TIME_W-1:0] expd,
                                        input logic [TIME_W-1:0] actual);
    if (expd !== actual) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expd, actual);
    end
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    pressure_result_t expd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, got %0h", $time, out_tdata);
      end else begin
        expd = pending_results.pop_front();
        compare_field("median_pa", 32'(expd.median_pa), 32'(out_tdata[16:0]));
        compare_field("median_time_ms", expd.median_time_ms, out_tdata[48:17]);
        compare_field("smooth_q8", 32'(expd.smooth_q8), 32'(out_tdata[73:49]));
        compare_field("smooth_pa", 32'(expd.smooth_pa), 32'(out_tdata[90:74]));
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_window_fill();
    test_time_order();
    test_time_constant();
    test_random_phase(260, '1, RX_RANDOM, 1'b1);
    test_random_phase(260, 16'd1, RX_PATTERN, 1'b0);
    test_random_phase(260, '0, RX_ALWAYS, 1'b0);
    test_random_phase(260, 16'($urandom_range(2, 65534)), RX_RANDOM, 1'b1);
    test_backpressure();
    settle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== spike_rejecting_iir_filter.f =====
hw/rtl/srif_pkg.sv
hw/rtl/srif_window.sv
hw/rtl/srif_div.sv
hw/rtl/srif_mul.sv
hw/rtl/spike_rejecting_iir_filter.sv
tb/spike_rejecting_iir_filter_tb.sv
